// ===== src/segx_pkg.sv =====
// segx_pkg: shared constants for the segment intersection pipeline
// no dependencies; used by segx_div, segment_intersection_2d and segx_chk

package segx_pkg;

  // default coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 32;
  // width of every coordinate field on the ports
  localparam int unsigned FIELD_W = 32;
  // quotient bits: one integer bit and 32 fraction bits
  localparam int unsigned QUOT_BITS = 33;
  localparam int unsigned QUOT_FRAC = 32;
  // restoring steps per divider stage
  localparam int unsigned DIV_STEPS = 3;

endpackage

// ===== src/segment_intersection_2d.sv =====
// segment_intersection_2d: streaming intersection of two 2d segments
// depends on segx_pkg and segx_div
//
// Usage: each input transfer carries segment a-b (with z) and segment c-d.
// The result transfer gives hit and the crossing point b + t*(a-b), with
// t found to 32 fraction bits and truncated; a miss (parallel, degenerate
// or outside either segment) gives hit low and zero coordinates.
// Both channels are valid/ready. From input transfer to result valid an item
// passes differences, products, sums, sign normalisation and range test,
// eleven divider stages of three quotient bits each, then the interpolation
// product and the final add.
// Throughput is one item per cycle; the whole pipeline advances whenever
// the output register is empty or its result is taken.
// When the receiver stalls, in_ready_o drops at once and every stage holds.
// Reset clears all valid bits; no clearing pass is needed.

module segment_intersection_2d #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [segx_pkg::FIELD_W-1:0] a_x_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] a_y_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] a_z_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] b_x_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] b_y_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] b_z_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] c_x_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] c_y_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] d_x_i,
  input  logic signed [segx_pkg::FIELD_W-1:0] d_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [segx_pkg::FIELD_W-1:0] cross_x_o,
  output logic signed [segx_pkg::FIELD_W-1:0] cross_y_o,
  output logic signed [segx_pkg::FIELD_W-1:0] cross_z_o
);

  localparam int unsigned FW  = segx_pkg::FIELD_W;
  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned QB  = segx_pkg::QUOT_BITS;
  localparam int unsigned RSW = DW + 2;
  localparam int unsigned SBW = 3 * DW + 3 * W;
  localparam int unsigned SDW = SBW + 1;

  logic en;
  logic out_valid_q;

  // whole pipeline moves when the output register is free
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // coordinate decode
  logic [FW-1:0]       raw [10];
  logic signed [W-1:0] crd [10];

  assign raw[0] = a_x_i;
  assign raw[1] = a_y_i;
  assign raw[2] = a_z_i;
  assign raw[3] = b_x_i;
  assign raw[4] = b_y_i;
  assign raw[5] = b_z_i;
  assign raw[6] = c_x_i;
  assign raw[7] = c_y_i;
  assign raw[8] = d_x_i;
  assign raw[9] = d_y_i;

  for (genvar k = 0; k < 10; k++) begin : g_crd
    if (W <= FW) begin : g_cut
      assign crd[k] = raw[k][W-1:0];
    end else begin : g_ext
      assign crd[k] = {{(W-FW){raw[k][FW-1]}}, raw[k]};
    end
  end

  // stage 1: differences
  logic                 v1_q;
  logic signed [DW-1:0] abx_q, aby_q, cdx_q, cdy_q, wx_q, wy_q;
  logic [SBW-1:0]       side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      abx_q <= DW'(crd[0]) - DW'(crd[3]);
      aby_q <= DW'(crd[1]) - DW'(crd[4]);
      cdx_q <= DW'(crd[8]) - DW'(crd[6]);
      cdy_q <= DW'(crd[9]) - DW'(crd[7]);
      wx_q  <= DW'(crd[8]) - DW'(crd[3]);
      wy_q  <= DW'(crd[9]) - DW'(crd[4]);
    end
  end

  // side data for interpolation: a-b and b for x, y, z
  logic [SBW-1:0] side1_d;
  assign side1_d = {DW'(crd[0]) - DW'(crd[3]), DW'(crd[1]) - DW'(crd[4]),
                    DW'(crd[2]) - DW'(crd[5]), crd[3], crd[4], crd[5]};

  always_ff @(posedge clk_i) begin
    if (en) side1_q <= side1_d;
  end

  // stage 2: the six cross products
  logic                 v2_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic [SBW-1:0]       side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= PW'(abx_q) * PW'(cdy_q);
      p2_q    <= PW'(cdx_q) * PW'(aby_q);
      p3_q    <= PW'(cdy_q) * PW'(wx_q);
      p4_q    <= PW'(-PW'(cdx_q)) * PW'(wy_q);
      p5_q    <= PW'(abx_q) * PW'(wy_q);
      p6_q    <= PW'(wx_q) * PW'(aby_q);
      side2_q <= side1_q;
    end
  end

  // stage 3: determinant and numerators
  logic                 v3_q;
  logic signed [NW-1:0] det_q, tn_q, sn_q;
  logic [SBW-1:0]       side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q   <= NW'(p1_q) - NW'(p2_q);
      tn_q    <= NW'(p3_q) + NW'(p4_q);
      sn_q    <= NW'(p5_q) - NW'(p6_q);
      side3_q <= side2_q;
    end
  end

  // stage 4: sign normalisation and range test
  logic                 v4_q;
  logic                 det_neg, hit4;
  logic signed [NW-1:0] detm, tnm, snm;
  logic [NW-1:0]        den4_q, num4_q;
  logic [SDW-1:0]       side4_q;

  always_comb begin
    det_neg = det_q[NW-1];
    detm    = det_neg ? -det_q : det_q;
    tnm     = det_neg ? -tn_q  : tn_q;
    snm     = det_neg ? -sn_q  : sn_q;
    hit4    = (det_q != '0) && !tnm[NW-1] && !snm[NW-1] && (tnm <= detm) && (snm <= detm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q  <= hit4 ? detm : NW'(1);
      num4_q  <= hit4 ? tnm  : '0;
      side4_q <= {hit4, side3_q};
    end
  end

  // divider stages: t = tn / det
  logic           vd;
  logic [QB-1:0]  quot;
  logic [SDW-1:0] sided;

  segx_div #(
    .NW (NW),
    .SW (SDW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .den_i   (den4_q),
    .num_i   (num4_q),
    .side_i  (side4_q),
    .valid_o (vd),
    .quot_o  (quot),
    .side_o  (sided)
  );

  // unpack side data
  logic                 hitd;
  logic signed [DW-1:0] dfx, dfy, dfz;
  logic signed [W-1:0]  bx, by, bz;

  assign {hitd, dfx, dfy, dfz, bx, by, bz} = sided;

  // interpolation stage 1: t times |a-b|
  logic                  vi_q, hiti_q, negx_q, negy_q, negz_q;
  logic [QB+DW-1:0]      mx_q, my_q, mz_q;
  logic signed [W-1:0]   bx_q, by_q, bz_q;
  logic [DW-1:0]         magx, magy, magz;

  assign magx = dfx[DW-1] ? DW'(-dfx) : DW'(dfx);
  assign magy = dfy[DW-1] ? DW'(-dfy) : DW'(dfy);
  assign magz = dfz[DW-1] ? DW'(-dfz) : DW'(dfz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
    end else if (en) begin
      vi_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= (QB+DW)'(quot) * (QB+DW)'(magx);
      my_q   <= (QB+DW)'(quot) * (QB+DW)'(magy);
      mz_q   <= (QB+DW)'(quot) * (QB+DW)'(magz);
      negx_q <= dfx[DW-1];
      negy_q <= dfy[DW-1];
      negz_q <= dfz[DW-1];
      bx_q   <= bx;
      by_q   <= by;
      bz_q   <= bz;
      hiti_q <= hitd;
    end
  end

  // interpolation stage 2: b plus or minus the truncated product
  logic [DW:0]           partx, party, partz;
  logic signed [RSW-1:0] resx, resy, resz;

  assign partx = (DW+1)'(mx_q >> segx_pkg::QUOT_FRAC);
  assign party = (DW+1)'(my_q >> segx_pkg::QUOT_FRAC);
  assign partz = (DW+1)'(mz_q >> segx_pkg::QUOT_FRAC);

  always_comb begin
    resx = negx_q ? RSW'(bx_q) - RSW'(partx) : RSW'(bx_q) + RSW'(partx);
    resy = negy_q ? RSW'(by_q) - RSW'(party) : RSW'(by_q) + RSW'(party);
    resz = negz_q ? RSW'(bz_q) - RSW'(partz) : RSW'(bz_q) + RSW'(partz);
  end

  // output register
  logic              hit_q;
  logic signed [FW-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hiti_q;
      cx_q  <= hiti_q ? FW'(resx) : '0;
      cy_q  <= hiti_q ? FW'(resy) : '0;
      cz_q  <= hiti_q ? FW'(resz) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;
  assign cross_z_o   = cz_q;

endmodule

// ===== src/segx_div.sv =====
// segx_div: pipelined restoring divider, a few quotient bits per stage
// depends on segx_pkg; side data travels alongside each quotient

module segx_div #(
  parameter int unsigned NW = 67,
  parameter int unsigned SW = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [NW-1:0]                   den_i,
  input  logic [NW-1:0]                   num_i,
  input  logic [SW-1:0]                   side_i,
  output logic                            valid_o,
  output logic [segx_pkg::QUOT_BITS-1:0]  quot_o,
  output logic [SW-1:0]                   side_o
);

  localparam int unsigned QB  = segx_pkg::QUOT_BITS;
  localparam int unsigned BPS = segx_pkg::DIV_STEPS;
  localparam int unsigned NST = (QB + BPS - 1) / BPS;
  localparam int unsigned RW  = NW + 1;

  logic [RW-1:0] rem_q [NST];
  logic [NW-1:0] den_q [NST];
  logic [QB-1:0] quo_q [NST];
  logic [SW-1:0] side_q[NST];
  logic          vld_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [RW-1:0] rem_in, rem_d;
    logic [NW-1:0] den_in;
    logic [QB-1:0] quo_in, quo_d;
    logic [SW-1:0] side_in;
    logic          vld_in;

    // stage inputs
    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // compare and subtract steps of this stage
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int unsigned j = 0; j < BPS; j++) begin
        if (k * BPS + j < QB) begin
          if (k * BPS + j > 0) rem_d = rem_d << 1;
          quo_d = quo_d << 1;
          if (rem_d >= {1'b0, den_in}) begin
            rem_d    = rem_d - {1'b0, den_in};
            quo_d[0] = 1'b1;
          end
        end
      end
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quot_o  = quo_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// ===== src/segx_chk.sv =====
// segx_chk: port-level checks for segment_intersection_2d
// depends on segx_pkg; bound to the top level below

module segx_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        hit_o,
  input logic [segx_pkg::FIELD_W-1:0] cross_x_o,
  input logic [segx_pkg::FIELD_W-1:0] cross_y_o,
  input logic [segx_pkg::FIELD_W-1:0] cross_z_o
);

  // a pending result stays until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // a miss carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> cross_x_o == '0 && cross_y_o == '0 && cross_z_o == '0)
    else $error("miss with nonzero point");

  // a stalled output stops intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // an empty output register never blocks intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with free output");

endmodule

bind segment_intersection_2d segx_chk u_segx_chk (.*);
